>>> design/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants for the rational fraction ALU
// Holds the transaction structs, operation codes, status codes and FSM states.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 32;
  localparam int unsigned MAG_W = 64;

  typedef enum logic [2:0] {
    FUNC_ADD = 3'd0,
    FUNC_SUB = 3'd1,
    FUNC_MUL = 3'd2,
    FUNC_DIV = 3'd3,
    FUNC_EQ  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic [63:0] res_num;
    logic [62:0] res_den;
    logic        equal;
    logic [1:0]  status;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_NEXT,
    S_DONE
  } state_t;

  // Divider request / response
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

>>> design/rfa_div.sv
// ----------------------------------------------------------------------------
// rfa_div: shared 64-bit unsigned restoring divider
// One quotient bit per cycle; raises done with quotient and remainder once all 64 bits are in.
// ----------------------------------------------------------------------------
module rfa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rfa_pkg::div_req_t req,
  output rfa_pkg::div_rsp_t rsp
);

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dsr_r, dsr_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic [64:0] shifted;

  // Shift one dividend bit in and try to subtract the divisor
  always_comb begin
    shifted  = {rem_r, quo_r[63]};
    trial    = shifted - {1'b0, dsr_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule

>>> design/rfa_ctrl.sv
// ----------------------------------------------------------------------------
// rfa_ctrl: sequencer and datapath registers
// Cross-multiplies, sums for add/subtract, runs Euclid's GCD on the shared divider, then
// divides both terms by the GCD. Equality runs the reduction twice.
// ----------------------------------------------------------------------------
module rfa_ctrl #(
  parameter int unsigned OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rfa_pkg::in_item_t   in_item,
  output logic                busy,
  output logic                out_valid,
  output rfa_pkg::out_item_t  out_item,
  output rfa_pkg::div_req_t   dreq,
  input  rfa_pkg::div_rsp_t   drsp
);

  localparam int unsigned OW = OPERAND_WIDTH;

  rfa_pkg::state_t state_r, state_nxt;

  // operand magnitudes and signs
  logic [OW-1:0] an_r, ad_r, bn_r, bd_r;
  logic          ans_r, ads_r, bns_r, bds_r;
  logic [2:0]    func_r;
  // products (magnitude / sign)
  logic [63:0]   p1_r, p2_r;
  logic          p1s_r, p2s_r;
  // fraction under reduction
  logic [63:0]   n_r, d_r;
  logic          ns_r;
  // GCD working values
  logic [63:0]   gx_r, gy_r;
  // saved first reduced fraction (equality)
  logic [63:0]   en_r, ed_r;
  logic          es_r;
  logic          pass_r;
  // a divider start is due in the current step
  logic          dv_go_r;
  logic          ovf_r;
  rfa_pkg::out_item_t res_r;
  logic          vld_r;

  logic          ld_ans, ld_ads, ld_bns, ld_bds;
  logic [OW-1:0] ld_an, ld_ad, ld_bn, ld_bd;

  logic [OW-1:0] mx, my;
  logic          mxs, mys;
  logic [63:0]   prod;
  logic          prod_s;
  logic [64:0]   sum;
  logic          sum_s;
  logic          fire;

  // magnitude of a sign-extended operand
  function automatic logic [OW-1:0] mag(input logic [31:0] raw);
    logic [OW-1:0] v;
    v = raw[OW-1:0];
    mag = v[OW-1] ? (~v + 1'b1) : v;
  endfunction

  assign fire = start && (state_r == rfa_pkg::S_IDLE) &&
                (in_item.func <= 3'(rfa_pkg::FUNC_EQ));

  assign ld_an  = mag(in_item.a_num);
  assign ld_ad  = mag(in_item.a_den);
  assign ld_bn  = mag(in_item.b_num);
  assign ld_bd  = mag(in_item.b_den);
  assign ld_ans = in_item.a_num[OW-1];
  assign ld_ads = in_item.a_den[OW-1];
  assign ld_bns = in_item.b_num[OW-1];
  assign ld_bds = in_item.b_den[OW-1];

  // select multiplier operands by step
  always_comb begin
    mx = an_r; mxs = ans_r; my = bd_r; mys = bds_r;
    case (state_r)
      rfa_pkg::S_MUL1: begin
        mx = an_r; mxs = ans_r;
        if (func_r == 3'(rfa_pkg::FUNC_MUL)) begin
          my = bn_r; mys = bns_r;
        end else begin
          my = bd_r; mys = bds_r;
        end
      end
      rfa_pkg::S_MUL2: begin
        if (func_r == 3'(rfa_pkg::FUNC_DIV)) begin
          mx = ad_r; mxs = ads_r; my = bn_r; mys = bns_r;
        end else if (func_r == 3'(rfa_pkg::FUNC_MUL)) begin
          mx = ad_r; mxs = ads_r; my = bd_r; mys = bds_r;
        end else begin
          mx = bn_r; mxs = bns_r ^ (func_r == 3'(rfa_pkg::FUNC_SUB));
          my = ad_r; mys = ads_r;
        end
      end
      rfa_pkg::S_MUL3: begin
        mx = ad_r; mxs = ads_r; my = bd_r; mys = bds_r;
      end
      default: begin
        mx = an_r; mxs = ans_r; my = bd_r; mys = bds_r;
      end
    endcase
    prod   = 64'(mx) * 64'(my);
    prod_s = (mxs ^ mys) && (prod != 64'd0);
  end

  // signed-magnitude add of the two cross products
  always_comb begin
    if (p1s_r == p2s_r) begin
      sum = {1'b0, p1_r} + {1'b0, p2_r}; sum_s = p1s_r;
    end else if (p1_r >= p2_r) begin
      sum = {1'b0, p1_r - p2_r}; sum_s = p1s_r;
    end else begin
      sum = {1'b0, p2_r - p1_r}; sum_s = p2s_r;
    end
    if (sum == 65'd0) sum_s = 1'b0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rfa_pkg::S_IDLE: if (fire) state_nxt = rfa_pkg::S_MUL1;
      rfa_pkg::S_MUL1: begin
        if (ad_r == '0 || bd_r == '0 ||
            (func_r == 3'(rfa_pkg::FUNC_DIV) && bn_r == '0))
          state_nxt = rfa_pkg::S_DONE;
        else if (func_r == 3'(rfa_pkg::FUNC_EQ))
          state_nxt = rfa_pkg::S_GCD;
        else
          state_nxt = rfa_pkg::S_MUL2;
      end
      rfa_pkg::S_MUL2: state_nxt = (func_r == 3'(rfa_pkg::FUNC_ADD) ||
                                    func_r == 3'(rfa_pkg::FUNC_SUB)) ?
                                   rfa_pkg::S_MUL3 : rfa_pkg::S_GCD;
      rfa_pkg::S_MUL3: state_nxt = rfa_pkg::S_SUM;
      rfa_pkg::S_SUM:  state_nxt = rfa_pkg::S_GCD;
      rfa_pkg::S_GCD:  if (gx_r == 64'd0 || gy_r == 64'd0 ||
                           (drsp.done && drsp.rem == 64'd0))
                         state_nxt = rfa_pkg::S_DIVN;
      rfa_pkg::S_DIVN: if (drsp.done) state_nxt = rfa_pkg::S_DIVD;
      rfa_pkg::S_DIVD: if (drsp.done) state_nxt =
                         (func_r == 3'(rfa_pkg::FUNC_EQ) && !pass_r) ?
                         rfa_pkg::S_NEXT : rfa_pkg::S_DONE;
      rfa_pkg::S_NEXT: state_nxt = rfa_pkg::S_GCD;
      rfa_pkg::S_DONE: state_nxt = rfa_pkg::S_IDLE;
      default:         state_nxt = rfa_pkg::S_IDLE;
    endcase
  end

  // divider requests: a start pulse on entry to or repeat within a step
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = gx_r;
    dreq.divisor  = gy_r;
    case (state_r)
      rfa_pkg::S_GCD: begin
        dreq.start = (gx_r != 64'd0 && gy_r != 64'd0) && dv_go_r;
      end
      rfa_pkg::S_DIVN: begin
        dreq.start = dv_go_r; dreq.dividend = n_r; dreq.divisor = gx_r;
      end
      rfa_pkg::S_DIVD: begin
        dreq.start = dv_go_r; dreq.dividend = d_r; dreq.divisor = gx_r;
      end
      default: dreq.start = 1'b0;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfa_pkg::S_IDLE;
      vld_r   <= 1'b0;
      dv_go_r <= 1'b0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= (state_r == rfa_pkg::S_DONE);
      case (state_r)
        rfa_pkg::S_IDLE: if (fire) begin
          func_r <= in_item.func;
          an_r <= ld_an; ad_r <= ld_ad; bn_r <= ld_bn; bd_r <= ld_bd;
          ans_r <= ld_ans; ads_r <= ld_ads; bns_r <= ld_bns; bds_r <= ld_bds;
          pass_r <= 1'b0;
          ovf_r  <= 1'b0;
          res_r  <= '0;
        end
        rfa_pkg::S_MUL1: begin
          p1_r <= prod; p1s_r <= prod_s;
          if (ad_r == '0 || bd_r == '0 ||
              (func_r == 3'(rfa_pkg::FUNC_DIV) && bn_r == '0)) begin
            res_r.status <= rfa_pkg::ST_DIV_ZERO;
          end else if (func_r == 3'(rfa_pkg::FUNC_EQ)) begin
            n_r <= 64'(an_r); d_r <= 64'(ad_r); ns_r <= ans_r ^ ads_r;
            gx_r <= 64'(an_r); gy_r <= 64'(ad_r);
            dv_go_r <= 1'b1;
          end
        end
        rfa_pkg::S_MUL2: begin
          p2_r <= prod; p2s_r <= prod_s;
          if (func_r == 3'(rfa_pkg::FUNC_MUL) || func_r == 3'(rfa_pkg::FUNC_DIV)) begin
            n_r <= p1_r; d_r <= prod; ns_r <= p1s_r ^ prod_s;
            gx_r <= p1_r; gy_r <= prod;
            dv_go_r <= 1'b1;
          end
        end
        rfa_pkg::S_MUL3: begin
          d_r <= prod;
        end
        rfa_pkg::S_SUM: begin
          // magnitude above 64 bits is latched in ovf_r and reported as overflow
          // after reduction; only the low 64 bits go through the gcd
          ovf_r <= sum[64];
          n_r <= sum[63:0]; ns_r <= sum_s ^ ads_r ^ bds_r;
          gx_r <= sum[63:0]; gy_r <= d_r;
          dv_go_r <= 1'b1;
        end
        rfa_pkg::S_GCD: begin
          dv_go_r <= 1'b0;
          if (gx_r == 64'd0 || gy_r == 64'd0) begin
            gx_r <= gx_r | gy_r;
            gy_r <= 64'd0;
            dv_go_r <= 1'b1;
          end else if (drsp.done) begin
            gx_r <= gy_r; gy_r <= drsp.rem;
            dv_go_r <= 1'b1;
          end
        end
        rfa_pkg::S_DIVN: begin
          dv_go_r <= 1'b0;
          if (drsp.done) begin
            n_r <= drsp.quot; dv_go_r <= 1'b1;
          end
        end
        rfa_pkg::S_DIVD: begin
          dv_go_r <= 1'b0;
          if (drsp.done) begin
            d_r <= drsp.quot;
            ns_r <= ns_r && (n_r != 64'd0);
          end
        end
        rfa_pkg::S_NEXT: begin
          en_r <= n_r; ed_r <= d_r; es_r <= ns_r;
          pass_r <= 1'b1;
          n_r <= 64'(bn_r); d_r <= 64'(bd_r); ns_r <= bns_r ^ bds_r;
          gx_r <= 64'(bn_r); gy_r <= 64'(bd_r);
          dv_go_r <= 1'b1;
        end
        rfa_pkg::S_DONE: begin
          if (res_r.status == rfa_pkg::ST_OK) begin
            if (func_r == 3'(rfa_pkg::FUNC_EQ)) begin
              res_r.equal <= (es_r == ns_r) && (en_r == n_r) && (ed_r == d_r);
            end else if (ovf_r || d_r[63] || (n_r[63] && !(ns_r && n_r[62:0] == '0))) begin
              res_r.status <= rfa_pkg::ST_OVERFLOW;
            end else begin
              res_r.res_num <= ns_r ? (~n_r + 64'd1) : n_r;
              res_r.res_den <= d_r[62:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign busy      = (state_r != rfa_pkg::S_IDLE);
  assign out_valid = vld_r;
  assign out_item  = res_r;

endmodule

>>> design/rational_fraction_alu_top.sv
// ----------------------------------------------------------------------------
// rational_fraction_alu_top: rational arithmetic with GCD reduction
// Add, subtract, multiply, divide or compare two signed fractions.
// ----------------------------------------------------------------------------
//  channel | ports                     | handshake
//  input   | start, busy, in_item      | taken when start && !busy
//  result  | out_valid, out_item       | one-cycle strobe, no back-pressure
//
//  Cross products run S_MUL1, S_MUL2, S_MUL3 and S_SUM for add/subtract,
//  S_MUL1 and S_MUL2 for multiply/divide, S_MUL1 alone for equality. Each
//  Euclid step and each of the two quotient divisions then runs on the shared
//  divider, so large coprime terms take longer; equality runs two reductions.
//  A zero denominator goes from S_MUL1 straight to S_DONE without reduction.
//  Reset is synchronous; no clearing pass. busy stays high until the result
//  strobe; the receiver cannot stall. Unknown operation codes are dropped.
module rational_fraction_alu_top #(
  parameter int unsigned OPERAND_WIDTH = rfa_pkg::OPERAND_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  rfa_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output rfa_pkg::out_item_t out_item
);

  rfa_pkg::div_req_t dreq;
  rfa_pkg::div_rsp_t drsp;
  logic              ctrl_busy;

  rfa_ctrl #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
    .busy(ctrl_busy), .out_valid(out_valid), .out_item(out_item),
    .dreq(dreq), .drsp(drsp)
  );

  rfa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign busy = ctrl_busy;

endmodule

>>> design/rfa_checker.sv
// ----------------------------------------------------------------------------
// rfa_checker: port-level checks for the rational fraction ALU
// Watches the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module rfa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input rfa_pkg::out_item_t out_item
);

  // busy is already low during the result strobe
  a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("strobe while busy");

  // two strobes never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double strobe");

  // errors carry a zero denominator
  a_err_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != rfa_pkg::ST_OK) |-> out_item.res_den == '0)
    else $error("error with nonzero denominator");

  // after start while idle, expect busy or no result strobe
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && $past(rst_n)) |=> (busy || !out_valid))
    else $error("accept did not start work");

endmodule

bind rational_fraction_alu_top rfa_checker u_rfa_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for rational_fraction_alu_top
// Drives a directed table and then random fraction transactions through the
// start/busy command port, predicts each reduced result in the bench (fixed rows carry their own) and
// compares every result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned N_RANDOM   = 1400;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYC  = 200;

  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } smag_t;

  typedef struct {
    rfa_pkg::in_item_t  item;
    bit                 fixed;
    rfa_pkg::out_item_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  rfa_pkg::in_item_t  in_item;
  logic               busy;
  logic               out_valid;
  rfa_pkg::out_item_t out_item;

  rfa_pkg::out_item_t pending_q[$];
  int unsigned        err_cnt;
  int unsigned        idle_cnt;
  int unsigned        sender_pct;
  dir_row_t           dir_rows[$];

  rational_fraction_alu_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Toggle the clock every half period
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Split a 32-bit operand into sign and magnitude
  function automatic smag_t load_op(logic [31:0] v);
    smag_t r;
    r.neg = v[31];
    r.mag = r.neg ? (64'({32'h0, ~v}) + 64'd1) : 64'(v);
    return r;
  endfunction

  function automatic smag_t mul_sm(smag_t x, smag_t y);
    smag_t r;
    r.mag = x.mag * y.mag;
    r.neg = (x.neg != y.neg) && (r.mag != 0);
    return r;
  endfunction

  function automatic smag_t add_sm(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (x != 0 && y != 0) begin
      t = y;
      y = x % y;
      x = t;
    end
    return x + y;
  endfunction

  // Divide out the common factor; sign ends in the numerator
  function automatic void reduce_frac(inout smag_t n, inout smag_t d);
    logic [63:0] g;
    bit          neg;
    g   = gcd64(n.mag, d.mag);
    neg = (n.neg != d.neg);
    if (g != 0) begin
      n.mag = n.mag / g;
      d.mag = d.mag / g;
    end
    n.neg = neg && (n.mag != 0);
    d.neg = 1'b0;
  endfunction

  // Compute the expected result of one transaction
  function automatic rfa_pkg::out_item_t predict_frac(rfa_pkg::in_item_t it);
    rfa_pkg::out_item_t r;
    smag_t              an, ad, bn, bd, n, d;
    r  = '0;
    an = load_op(it.a_num);
    ad = load_op(it.a_den);
    bn = load_op(it.b_num);
    bd = load_op(it.b_den);
    if (ad.mag == 0 || bd.mag == 0) begin
      r.status = rfa_pkg::ST_DIV_ZERO;
      return r;
    end
    if (it.func == rfa_pkg::FUNC_EQ) begin
      reduce_frac(an, ad);
      reduce_frac(bn, bd);
      r.equal = (an.neg == bn.neg && an.mag == bn.mag && ad.mag == bd.mag);
      return r;
    end
    case (it.func)
      rfa_pkg::FUNC_ADD: begin
        n = add_sm(mul_sm(an, bd), mul_sm(bn, ad));
        d = mul_sm(ad, bd);
      end
      rfa_pkg::FUNC_SUB: begin
        bn.neg = !bn.neg && (bn.mag != 0);
        n = add_sm(mul_sm(an, bd), mul_sm(bn, ad));
        d = mul_sm(ad, bd);
      end
      rfa_pkg::FUNC_MUL: begin
        n = mul_sm(an, bn);
        d = mul_sm(ad, bd);
      end
      default: begin
        if (bn.mag == 0) begin
          r.status = rfa_pkg::ST_DIV_ZERO;
          return r;
        end
        n = mul_sm(an, bd);
        d = mul_sm(ad, bn);
      end
    endcase
    reduce_frac(n, d);
    if ((!n.neg && n.mag > 64'h7FFF_FFFF_FFFF_FFFF) ||
        (n.neg && n.mag > 64'h8000_0000_0000_0000) ||
        d.mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
      r.status = rfa_pkg::ST_OVERFLOW;
      return r;
    end
    r.res_num = n.neg ? (~n.mag + 64'd1) : n.mag;
    r.res_den = d.mag[62:0];
    r.status  = rfa_pkg::ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic rfa_pkg::in_item_t mk_item(logic [2:0] f, logic [31:0] an,
                                                logic [31:0] ad, logic [31:0] bn,
                                                logic [31:0] bd);
    rfa_pkg::in_item_t it;
    it.func  = f;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  function automatic rfa_pkg::out_item_t mk_res(logic [63:0] n, logic [62:0] d, logic eq,
                                                rfa_pkg::status_t st);
    rfa_pkg::out_item_t r;
    r.res_num = n;
    r.res_den = d;
    r.equal   = eq;
    r.status  = st;
    return r;
  endfunction

  task automatic add_row(rfa_pkg::in_item_t it, bit fixed, rfa_pkg::out_item_t want);
    dir_row_t row;
    row.item  = it;
    row.fixed = fixed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Pick an operand: mostly small, some 16-bit, a few full width or extreme
  function automatic logic [31:0] rand_op();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 72) return 32'($signed($urandom_range(400)) - 200);
    if (sel < 88) return 32'($signed($urandom_range(65535)) - 32768);
    if (sel < 94) begin
      case ($urandom_range(4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        3: return 32'h0000_0001;
        default: return 32'h0;
      endcase
    end
    return $urandom();
  endfunction

  // Present one transaction and hold it until taken
  task automatic send_item(rfa_pkg::in_item_t it, bit fixed, rfa_pkg::out_item_t want);
    while ($urandom_range(99) < sender_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (it.func <= rfa_pkg::FUNC_EQ) pending_q.push_back(fixed ? want : predict_frac(it));
    @(negedge clk);
  endtask

  // Check each result strobe and watch for a stalled run
  always @(posedge clk) begin
    rfa_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected result", out_item.res_num, 64'h0);
        end else begin
          want = pending_q.pop_front();
          if (out_item.res_num !== want.res_num)
            report_mismatch("res_num", out_item.res_num, want.res_num);
          if (out_item.res_den !== want.res_den)
            report_mismatch("res_den", 64'(out_item.res_den), 64'(want.res_den));
          if (out_item.equal !== want.equal)
            report_mismatch("equal", 64'(out_item.equal), 64'(want.equal));
          if (out_item.status !== want.status)
            report_mismatch("status", 64'(out_item.status), 64'(want.status));
        end
      end
      if (out_valid || (start && !busy)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rfa_pkg::in_item_t it;
    int unsigned       f;
    err_cnt    = 0;
    idle_cnt   = 0;
    sender_pct = 13;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: fixed expectations where obvious, predictor otherwise
    add_row(mk_item(rfa_pkg::FUNC_ADD, 32'd1, 32'd2, 32'd1, 32'd3), 1,
            mk_res(64'd5, 63'd6, 1'b0, rfa_pkg::ST_OK));
    add_row(mk_item(rfa_pkg::FUNC_ADD, 32'd0, 32'd5, 32'd0, 32'd7), 1,
            mk_res(64'd0, 63'd1, 1'b0, rfa_pkg::ST_OK));
    add_row(mk_item(rfa_pkg::FUNC_MUL, 32'd0, 32'h8000_0000, 32'd9, 32'd4), 1,
            mk_res(64'd0, 63'd1, 1'b0, rfa_pkg::ST_OK));
    add_row(mk_item(rfa_pkg::FUNC_ADD, 32'd3, 32'd0, 32'd1, 32'd2), 1,
            mk_res(64'd0, 63'd0, 1'b0, rfa_pkg::ST_DIV_ZERO));
    add_row(mk_item(rfa_pkg::FUNC_EQ, 32'd3, 32'd4, 32'd1, 32'd0), 1,
            mk_res(64'd0, 63'd0, 1'b0, rfa_pkg::ST_DIV_ZERO));
    add_row(mk_item(rfa_pkg::FUNC_DIV, 32'd3, 32'd4, 32'd0, 32'd5), 1,
            mk_res(64'd0, 63'd0, 1'b0, rfa_pkg::ST_DIV_ZERO));
    add_row(mk_item(rfa_pkg::FUNC_EQ, 32'd1, 32'd2, 32'd2, 32'd4), 1,
            mk_res(64'd0, 63'd0, 1'b1, rfa_pkg::ST_OK));
    add_row(mk_item(rfa_pkg::FUNC_EQ, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'hFFFF_FFFE), 1,
            mk_res(64'd0, 63'd0, 1'b1, rfa_pkg::ST_OK));
    add_row(mk_item(rfa_pkg::FUNC_EQ, 32'd1, 32'd2, 32'd1, 32'd3), 1,
            mk_res(64'd0, 63'd0, 1'b0, rfa_pkg::ST_OK));
    add_row(mk_item(rfa_pkg::FUNC_SUB, 32'd1, 32'd2, 32'd1, 32'd2), 1,
            mk_res(64'd0, 63'd1, 1'b0, rfa_pkg::ST_OK));
    add_row(mk_item(rfa_pkg::FUNC_MUL, 32'd2, 32'hFFFF_FFFD, 32'd3, 32'd4), 0, '0);
    add_row(mk_item(rfa_pkg::FUNC_DIV, 32'hFFFF_FFF9, 32'd3, 32'hFFFF_FFFE, 32'd5),
            0, '0);
    add_row(mk_item(rfa_pkg::FUNC_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000), 0, '0);
    add_row(mk_item(rfa_pkg::FUNC_SUB, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
                    32'h7FFF_FFFF), 0, '0);
    add_row(mk_item(rfa_pkg::FUNC_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1),
            0, '0);
    add_row(mk_item(rfa_pkg::FUNC_DIV, 32'h8000_0000, 32'd1, 32'd1, 32'h8000_0000),
            0, '0);
    add_row(mk_item(rfa_pkg::FUNC_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFD,
                    32'h7FFF_FFFF), 0, '0);
    add_row(mk_item(rfa_pkg::FUNC_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000,
                    32'h7FFF_FFFD), 0, '0);
    add_row(mk_item(rfa_pkg::FUNC_EQ, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1),
            0, '0);
    add_row(mk_item(3'd5, 32'd1, 32'd2, 32'd3, 32'd4), 0, '0);
    add_row(mk_item(3'd7, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0), 0, '0);
    add_row(mk_item(rfa_pkg::FUNC_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF), 0, '0);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);

    // Random part in three idling phases
    for (int unsigned k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) sender_pct = 61;
      if (k == 2 * N_RANDOM / 3) sender_pct = 0;
      f = $urandom_range(99);
      it.func  = (f < 4) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      it.a_num = rand_op();
      it.a_den = rand_op();
      it.b_num = rand_op();
      it.b_den = rand_op();
      // Keep denominators mostly nonzero so reductions are exercised
      if (it.a_den == 0 && $urandom_range(3) != 0) it.a_den = 32'd1;
      if (it.b_den == 0 && $urandom_range(3) != 0) it.b_den = 32'hFFFF_FFFF;
      send_item(it, 0, '0);
    end
    start <= 1'b0;

    // Drain outstanding results, then allow a quiet tail
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
